>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mbr_pkg.sv
// ----------------------------------------------------------------------------
// mbr_pkg
// Types and codes for the MSB-first bit reader.
// ----------------------------------------------------------------------------
package mbr_pkg;

    localparam int MAX_BITS = 64;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COUNT = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_TAKE,
        S_DONE
    } t_state;

endpackage

>>> rtl/msb_first_bit_reader_core.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader_core
// Byte FIFO with an MSB-first bit extractor that hands out 1 to 64 bits.
// ----------------------------------------------------------------------------
// A push stores one byte and a read returns up to 64 bits, MSB first, from
// the oldest buffered byte; every item gives one result. The block takes one
// item at a time. A push or a rejected read goes straight to the done state.
// A good read passes a fetch state, then a take state for each stored byte it
// touches (1 to 9), then the done state: the byte store delivers one
// registered byte per cycle, and the extractor takes up to 8 bits of it.
// Ready returns in the cycle the result appears. The result sits in an
// output register, so the next item is accepted while it waits to be taken;
// a later item that finishes before that result is taken holds in its done
// state until it is.
`include "assert_macros.svh"

module msb_first_bit_reader_core
    import mbr_pkg::*;
#(
    parameter int STORE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_nbits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_word,
    output logic [1:0]  o_status,
    output logic [7:0]  o_bits_left
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int BW = (CW + 3 > 8) ? CW + 3 : 8;

    logic [7:0]    r_mem [STORE_DEPTH];
    logic [7:0]    r_rd_q;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_bitpos, n_bitpos;
    logic [6:0]    r_remain, n_remain;
    logic [63:0]   r_word, n_word;
    t_status       r_status, n_status;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_o_word;
    logic [1:0]    r_o_status;
    logic [7:0]    r_o_bits_left;

    logic          acc;
    logic          is_read;
    logic          bad_count;
    logic          underflow;
    logic          full;
    logic          out_free;
    logic          wr_en;
    logic [BW-1:0] buffered;
    logic [3:0]    avail;
    logic [3:0]    take;
    logic [7:0]    mask;
    logic [7:0]    chunk;
    logic          last_chunk;

    function automatic logic [AW-1:0] next_index(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        if (idx == AW'(STORE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + AW'(1);
        end
        return res;
    endfunction

    // Decode and status checks
    always_comb begin
        acc       = i_valid && o_ready;
        is_read   = (t_op'(i_op) == OP_READ);
        full      = (r_count >= CW'(STORE_DEPTH));
        bad_count = (i_nbits == 8'd0) || (i_nbits > 8'(MAX_BITS));
        if (r_count == '0) begin
            buffered = '0;
        end else begin
            buffered = BW'({r_count, 3'b000}) - BW'(3'd7 - r_bitpos);
        end
        underflow = (BW'(i_nbits) > buffered);
        out_free  = !r_out_valid || i_ready;
        wr_en     = acc && !is_read && !full;
    end

    // Bit extraction from the current head byte
    always_comb begin
        avail      = {1'b0, r_bitpos} + 4'd1;
        take       = (r_remain < 7'(avail)) ? r_remain[3:0] : avail;
        mask       = 8'((9'd1 << take) - 9'd1);
        chunk      = (r_rd_q >> (avail - take)) & mask;
        last_chunk = (7'(take) == r_remain);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (is_read && !bad_count && !underflow) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: n_state = S_TAKE;
            S_TAKE: begin
                if (last_chunk) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_bitpos    = r_bitpos;
        n_remain    = r_remain;
        n_word      = r_word;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_word   = '0;
                    n_status = ST_OK;
                    if (!is_read) begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_tail  = next_index(r_tail);
                            n_count = r_count + CW'(1);
                        end
                    end else if (bad_count) begin
                        n_status = ST_BAD_COUNT;
                    end else if (underflow) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_remain = i_nbits[6:0];
                    end
                end
            end
            S_FETCH: begin
            end
            S_TAKE: begin
                n_word   = (r_word << take) | {56'd0, chunk};
                n_remain = r_remain - 7'(take);
                if (take == avail) begin
                    // drop the exhausted byte
                    n_bitpos = 3'd7;
                    n_head   = next_index(r_head);
                    n_count  = r_count - CW'(1);
                end else begin
                    n_bitpos = r_bitpos - take[2:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bitpos    <= 3'd7;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_bitpos    <= n_bitpos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain <= n_remain;
        r_word   <= n_word;
        r_status <= n_status;
        if (r_state == S_DONE && out_free) begin
            r_o_word      <= r_word;
            r_o_status    <= r_status;
            r_o_bits_left <= buffered[7:0];
        end
    end

    // Byte store: at most one write and one read per cycle, read data registered.
    // Read at the upcoming head so the byte is ready when extraction needs it.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_data_byte;
        end
        r_rd_q <= r_mem[n_head];
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_word      = r_o_word;
    assign o_status    = r_o_status;
    assign o_bits_left = r_o_bits_left;

    `MBR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STORE_DEPTH), "byte count beyond store depth")
    `MBR_ASSERT_NOW(a_empty_msb, i_clk, i_rst_n, r_count == '0, r_bitpos == 3'd7, "empty store not aligned to MSB")
    `MBR_ASSERT_NEXT(a_drop_byte, i_clk, i_rst_n, (r_state == S_TAKE) && (take == avail), r_count == $past(r_count) - CW'(1), "exhausted byte not released")

endmodule

>>> tb/msb_first_bit_reader_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_reader_checker
// Watches both channels of the bit reader, predicts every result from each
// accepted item and compares it, field by field, with what comes out.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_checker
    import mbr_pkg::*;
#(
    parameter int STORE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_nbits,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [63:0] o_word,
    input  logic [1:0]  o_status,
    input  logic [7:0]  o_bits_left,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_flagged
);

    typedef struct packed {
        logic [63:0] word;
        t_status     status;
        logic [7:0]  bits_left;
    } t_bit_result;

    localparam int MAX_PRINTS = 100;

    // Shadow of the byte store and read pointer
    logic [7:0]  shadow_bytes [STORE_DEPTH];
    int unsigned head_q;
    int unsigned tail_q;
    int unsigned count_q;
    int unsigned bit_pos_q;

    t_bit_result expected_results[$];
    int          mismatches;
    int          results_seen;
    int          flagged_seen;

    assign o_fail_count = mismatches;
    assign o_checked    = results_seen;
    assign o_flagged    = flagged_seen;

    initial begin
        head_q       = 0;
        tail_q       = 0;
        count_q      = 0;
        bit_pos_q    = 7;
        mismatches   = 0;
        results_seen = 0;
        flagged_seen = 0;
        o_pending    = 0;
    end

    function automatic int unsigned bits_buffered();
        if (count_q == 0) begin
            return 0;
        end
        return count_q * 8 - (7 - bit_pos_q);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic predict_bits(input t_op op, input logic [7:0] data, input logic [7:0] nb);
        t_bit_result res;
        int unsigned k;
        res.word   = '0;
        res.status = ST_OK;
        if (op == OP_PUSH) begin
            if (count_q >= STORE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_bytes[tail_q] = data;
                tail_q = (tail_q + 1) % STORE_DEPTH;
                count_q++;
            end
        end else if (nb == 0 || nb > MAX_BITS) begin
            res.status = ST_BAD_COUNT;
        end else if (nb > bits_buffered()) begin
            res.status = ST_UNDERFLOW;
        end else begin
            for (k = 0; k < nb; k++) begin
                res.word = {res.word[62:0], shadow_bytes[head_q][bit_pos_q]};
                // Release the head byte once its last bit is gone
                if (bit_pos_q == 0) begin
                    bit_pos_q = 7;
                    head_q    = (head_q + 1) % STORE_DEPTH;
                    count_q--;
                end else begin
                    bit_pos_q--;
                end
            end
        end
        res.bits_left = 8'(bits_buffered());
        expected_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_bit_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word=%h status=%0d",
                                              o_word, o_status));
                end else begin
                    want = expected_results.pop_front();
                    if (want.status != ST_OK) begin
                        flagged_seen++;
                    end
                    if (o_word !== want.word) begin
                        report_mismatch($sformatf("word got %h want %h", o_word, want.word));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  o_status, want.status));
                    end
                    if (o_bits_left !== want.bits_left) begin
                        report_mismatch($sformatf("bits_left got %0d want %0d",
                                                  o_bits_left, want.bits_left));
                    end
                end
            end
            if (i_valid && o_ready) begin
                predict_bits(t_op'(i_op), i_data_byte, i_nbits);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> tb/tb_msb_first_bit_reader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_reader_core
// Drives pushes and reads into the MSB-first bit reader under changing
// idle and stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_reader_core;
    import mbr_pkg::*;

    localparam int          STORE_DEPTH  = 16;
    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 6;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          PHASE_ITEMS  = 500;
    localparam int          SETTLE       = 24;
    localparam longint      RUN_LIMIT_NS = 64'd5_000_000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_op        = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic [7:0]  i_nbits     = 8'h00;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_word;
    logic [1:0]  o_status;
    logic [7:0]  o_bits_left;

    int fail_count;
    int pending;
    int checked;
    int flagged;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int unsigned items_sent     = 0;
    int unsigned pushes_sent    = 0;
    int unsigned reads_sent     = 0;

    msb_first_bit_reader_core #(
        .STORE_DEPTH(STORE_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_data_byte(i_data_byte),
        .i_nbits(i_nbits),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_word(o_word),
        .o_status(o_status),
        .o_bits_left(o_bits_left)
    );

    msb_first_bit_reader_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_data_byte(i_data_byte),
        .i_nbits(i_nbits),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_word(o_word),
        .o_status(o_status),
        .o_bits_left(o_bits_left),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked),
        .o_flagged(flagged)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input t_op op, input logic [7:0] data, input logic [7:0] nb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= data;
        i_nbits     <= nb;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (op == OP_PUSH) begin
            pushes_sent++;
        end else begin
            reads_sent++;
        end
    endtask

    // The pending count is registered, so it lags the last acceptance
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // A run of pushes followed by a run of reads, mostly well-formed counts
    task automatic send_burst();
        int unsigned n_push;
        int unsigned n_read;
        int unsigned k;
        int unsigned pick;
        logic [7:0]  nb;
        n_push = $urandom_range(0, 12);
        n_read = $urandom_range(0, 6);
        for (k = 0; k < n_push; k++) begin
            send_item(OP_PUSH, 8'($urandom), 8'($urandom));
        end
        for (k = 0; k < n_read; k++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                nb = 8'($urandom_range(1, 16));
            end else if (pick < 90) begin
                nb = 8'($urandom_range(17, MAX_BITS));
            end else if (pick < 95) begin
                nb = 8'd0;
            end else begin
                nb = 8'($urandom_range(MAX_BITS + 1, 255));
            end
            send_item(OP_READ, 8'($urandom), nb);
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned k;
        logic [7:0]  fill_bytes [6];

        fill_bytes = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80, 8'h01};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, bad counts, fill to the top, overflow,
        // boundary reads and an underflow at a byte boundary
        send_item(OP_READ, 8'hFF, 8'd8);
        send_item(OP_READ, 8'h00, 8'd0);
        send_item(OP_READ, 8'hFF, 8'd65);
        send_item(OP_READ, 8'h00, 8'd255);
        for (k = 0; k < STORE_DEPTH; k++) begin
            send_item(OP_PUSH, (k < 6) ? fill_bytes[k] : 8'($urandom), 8'($urandom));
        end
        send_item(OP_PUSH, 8'h3C, 8'd64);
        send_item(OP_READ, 8'($urandom), 8'd1);
        send_item(OP_READ, 8'($urandom), 8'd64);
        send_item(OP_READ, 8'($urandom), 8'd7);
        send_item(OP_READ, 8'($urandom), 8'd64);
        send_item(OP_READ, 8'($urandom), 8'd56);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // Hold the result side off so the block backs up
                    hold_req = 1'b1;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            k = items_sent + PHASE_ITEMS;
            while (items_sent < k) begin
                send_burst();
            end
            // Pause until every outstanding result is back
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d items: %0d pushes and %0d reads over four idle/stall phases",
                 items_sent, pushes_sent, reads_sent);
        $display("Checked %0d results, %0d of them full, underflow or bad-count flags",
                 checked, flagged);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
